/* hw/rtl/rct_pkg.sv */
package rct_pkg;

  localparam int KEY_W       = 32;
  localparam int SLOT_W      = 6;
  localparam int COUNT_OUT_W = 16;

  // result status codes
  typedef enum logic [2:0] {
    ST_EXISTING = 3'd0,
    ST_NEW      = 3'd1,
    ST_FULL     = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_FREED    = 3'd4,
    ST_INVALID  = 3'd5
  } status_t;

  // request kinds
  localparam logic KIND_OPEN  = 1'b0;
  localparam logic KIND_CLOSE = 1'b1;

  typedef struct packed {
    logic             kind;
    logic [KEY_W-1:0] key;
  } in_item_t;

  typedef struct packed {
    status_t                status;
    logic [SLOT_W-1:0]      slot;
    logic [COUNT_OUT_W-1:0] count_after;
  } out_item_t;

  // outcome of a table scan, handed to the update logic
  typedef struct packed {
    logic kind;
    logic zero_key;
    logic hit;
    logic have_free;
  } scan_flags_t;

endpackage

/* hw/rtl/rct_update.sv */
module rct_update
  import rct_pkg::*;
#(
  parameter int SLOTS      = 64,
  parameter int COUNT_BITS = 16
) (
  input  scan_flags_t                   flags,
  input  logic [KEY_W-1:0]              key,
  input  logic [$clog2(SLOTS)-1:0]      hit_idx,
  input  logic [$clog2(SLOTS)-1:0]      free_idx,
  input  logic [COUNT_BITS-1:0]         hit_refs,
  output logic                          wr_en,
  output logic [$clog2(SLOTS)-1:0]      wr_addr,
  output logic [KEY_W-1:0]              wr_key,
  output logic [COUNT_BITS-1:0]         wr_refs,
  output out_item_t                     res
);

  localparam int IDXW = $clog2(SLOTS);
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

  logic [IDXW-1:0]       res_idx;
  logic [COUNT_BITS-1:0] res_cnt;
  logic [IDXW+SLOT_W-1:0]           idx_ext;
  logic [COUNT_BITS+COUNT_OUT_W-1:0] cnt_ext;

  // decide write-back and result from the scan outcome
  always_comb begin
    wr_en      = 1'b0;
    wr_addr    = hit_idx;
    wr_key     = key;
    wr_refs    = hit_refs;
    res_idx    = '0;
    res_cnt    = '0;
    res.status = ST_INVALID;
    if (flags.zero_key) begin
      res.status = ST_INVALID;
    end else if (flags.kind == KIND_OPEN) begin
      if (flags.hit) begin
        res_idx = hit_idx;
        if (hit_refs == CNT_MAX) begin
          // saturated, leave the entry alone
          res.status = ST_INVALID;
          res_cnt    = CNT_MAX;
        end else begin
          wr_en      = 1'b1;
          wr_refs    = hit_refs + CNT_ONE;
          res.status = ST_EXISTING;
          res_cnt    = hit_refs + CNT_ONE;
        end
      end else if (flags.have_free) begin
        wr_en      = 1'b1;
        wr_addr    = free_idx;
        wr_refs    = CNT_ONE;
        res_idx    = free_idx;
        res_cnt    = CNT_ONE;
        res.status = ST_NEW;
      end else begin
        res.status = ST_FULL;
      end
    end else begin
      if (!flags.hit) begin
        res.status = ST_NOTFOUND;
      end else if (hit_refs <= CNT_ONE) begin
        // last reference gone, free the slot
        wr_en      = 1'b1;
        wr_key     = '0;
        wr_refs    = '0;
        res_idx    = hit_idx;
        res.status = ST_FREED;
      end else begin
        wr_en      = 1'b1;
        wr_refs    = hit_refs - CNT_ONE;
        res_idx    = hit_idx;
        res_cnt    = hit_refs - CNT_ONE;
        res.status = ST_EXISTING;
      end
    end

    // result fields carry the low bits of index and count
    idx_ext         = {{SLOT_W{1'b0}}, res_idx};
    cnt_ext         = {{COUNT_OUT_W{1'b0}}, res_cnt};
    res.slot        = idx_ext[SLOT_W-1:0];
    res.count_after = cnt_ext[COUNT_OUT_W-1:0];
  end

endmodule

/* hw/rtl/refcounted_shared_id_table_core.sv */
// channel | direction | handshake            | payload
// in      | input     | in_valid / in_ready   | in_data  (kind, key)
// out     | output    | out_valid / out_ready | out_data (status, slot, count_after)
//
// A request scans the key/count memories with one read per slot, then drains the
// read pipe and writes back.
// A request with key 0 skips the scan and goes straight to the finishing step.
// After reset a clearing pass writes every slot with in_ready low.
// A stalled result waits in the output register; the next request may scan
// meanwhile and holds at write-back until that register frees up.
module refcounted_shared_id_table_core
  import rct_pkg::*;
#(
  parameter int SLOTS      = 64,
  parameter int COUNT_BITS = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int IDXW = $clog2(SLOTS);
  localparam logic [IDXW-1:0] LAST_IDX = IDXW'(SLOTS - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_FINISH
  } state_t;

  state_t state;

  // slot memories
  logic [KEY_W-1:0]      mem_key  [SLOTS];
  logic [COUNT_BITS-1:0] mem_refs [SLOTS];

  logic [IDXW-1:0]       cnt;
  logic                  rd_vld;
  logic [IDXW-1:0]       rd_idx;
  logic [KEY_W-1:0]      rd_key;
  logic [COUNT_BITS-1:0] rd_refs;

  in_item_t              req;
  scan_flags_t           flags;
  logic [IDXW-1:0]       hit_idx;
  logic [IDXW-1:0]       free_idx;
  logic [COUNT_BITS-1:0] hit_refs;

  logic                  upd_wr_en;
  logic [IDXW-1:0]       upd_wr_addr;
  logic [KEY_W-1:0]      upd_wr_key;
  logic [COUNT_BITS-1:0] upd_wr_refs;
  out_item_t             upd_res;

  logic                  fire;
  logic                  mem_we;
  logic [IDXW-1:0]       mem_waddr;
  logic [KEY_W-1:0]      mem_wkey;
  logic [COUNT_BITS-1:0] mem_wrefs;

  assign in_ready = (state == S_IDLE);
  assign fire     = (state == S_FINISH) && (!out_valid || out_ready);

  // write port: clearing pass or write-back
  always_comb begin
    if (state == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = cnt;
      mem_wkey  = '0;
      mem_wrefs = '0;
    end else begin
      mem_we    = fire && upd_wr_en;
      mem_waddr = upd_wr_addr;
      mem_wkey  = upd_wr_key;
      mem_wrefs = upd_wr_refs;
    end
  end

  // memory access, read data registered
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_key[mem_waddr]  <= mem_wkey;
      mem_refs[mem_waddr] <= mem_wrefs;
    end
    if (state == S_SCAN) begin
      rd_key  <= mem_key[cnt];
      rd_refs <= mem_refs[cnt];
    end
  end

  rct_update #(
    .SLOTS      (SLOTS),
    .COUNT_BITS (COUNT_BITS)
  ) u_update (
    .flags    (flags),
    .key      (req.key),
    .hit_idx  (hit_idx),
    .free_idx (free_idx),
    .hit_refs (hit_refs),
    .wr_en    (upd_wr_en),
    .wr_addr  (upd_wr_addr),
    .wr_key   (upd_wr_key),
    .wr_refs  (upd_wr_refs),
    .res      (upd_res)
  );

  // sequencer, scan bookkeeping and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      cnt       <= '0;
      rd_vld    <= 1'b0;
      out_valid <= 1'b0;
      flags     <= '0;
    end else begin
      rd_vld <= (state == S_SCAN);
      rd_idx <= cnt;

      // first match and first free slot, in index order
      if (rd_vld) begin
        if (!flags.hit && rd_key == req.key) begin
          flags.hit <= 1'b1;
          hit_idx   <= rd_idx;
          hit_refs  <= rd_refs;
        end
        if (!flags.have_free && rd_key == '0) begin
          flags.have_free <= 1'b1;
          free_idx        <= rd_idx;
        end
      end

      // output transfer frees the register unless a new result lands
      if (out_valid && out_ready && !fire) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_CLEAR: begin
          if (cnt == LAST_IDX) begin
            cnt   <= '0;
            state <= S_IDLE;
          end else begin
            cnt <= cnt + IDXW'(1);
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            req             <= in_data;
            flags.kind      <= in_data.kind;
            flags.zero_key  <= (in_data.key == '0);
            flags.hit       <= 1'b0;
            flags.have_free <= 1'b0;
            cnt             <= '0;
            state           <= (in_data.key == '0) ? S_FINISH : S_SCAN;
          end
        end
        S_SCAN: begin
          if (cnt == LAST_IDX) begin
            cnt   <= '0;
            state <= S_DRAIN;
          end else begin
            cnt <= cnt + IDXW'(1);
          end
        end
        S_DRAIN: begin
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (fire) begin
            out_data  <= upd_res;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // a taken request blocks the input until its result is written
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted twice without a write-back");

  // match and free slot can never be the same entry
  a_hit_free_apart: assert property (@(posedge clk) disable iff (rst)
    (flags.hit && flags.have_free) |-> (hit_idx != free_idx))
    else $error("matched slot also seen as free");

  // freed slots report zero, claimed slots report one
  a_result_counts: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_data.status != ST_FREED || out_data.count_after == '0) &&
                   (out_data.status != ST_NEW || out_data.count_after == COUNT_OUT_W'(1))))
    else $error("result count inconsistent with status");

  // no write-back outside the finishing step after reset clearing
  a_write_only_at_finish: assert property (@(posedge clk) disable iff (rst)
    (mem_we && state != S_CLEAR) |-> (state == S_FINISH && !flags.zero_key))
    else $error("unexpected memory write");

endmodule
